FILE: src/rrts_pkg.sv
// ----------------------------------------------------------------------------
// rrts_pkg: shared types and constants of the round-robin thread scheduler
// Request and response payloads, command, mode and status codes, sequencer
// states and the operation codes of the shared arithmetic unit.
// ----------------------------------------------------------------------------
package rrts_pkg;

  localparam int unsigned MAX_SLOTS_DEF  = 32;
  localparam int unsigned DATA_W         = 32;
  localparam logic [7:0]  SLEEP_COMP_RST = 8'd10;

  typedef enum logic [2:0] {
    CMD_TICK    = 3'd0,
    CMD_CREATE  = 3'd1,
    CMD_SLEEP   = 3'd2,
    CMD_KILL    = 3'd3,
    CMD_PAUSE   = 3'd4,
    CMD_UNPAUSE = 3'd5
  } rrts_cmd_e;

  typedef enum logic [1:0] {
    MODE_RUNNING  = 2'd0,
    MODE_SLEEPING = 2'd1,
    MODE_PAUSED   = 2'd2,
    MODE_KILLREQ  = 2'd3
  } rrts_mode_e;

  typedef enum logic [1:0] {
    ST_DONE    = 2'd0,
    ST_FULL    = 2'd1,
    ST_IGNORED = 2'd2
  } rrts_status_e;

  typedef enum logic {
    ALU_SUB     = 1'b0,
    ALU_ADD_SAT = 1'b1
  } rrts_alu_op_e;

  typedef enum logic [3:0] {
    S_IDLE,
    S_EXEC,
    S_CREATE,
    S_ADV_RD,
    S_ADV_CHK,
    S_REB_START,
    S_REB,
    S_TIME,
    S_DONE
  } rrts_state_e;

  typedef struct packed {
    logic [2:0]  command;
    logic [4:0]  thread_id;
    logic [31:0] sleep_ms;
    logic [15:0] time_passed;
  } rrts_req_t;

  typedef struct packed {
    logic [4:0] current_thread;
    logic       idle;
    logic [4:0] new_thread;
    logic [1:0] status;
  } rrts_rsp_t;

endpackage

FILE: src/rrts_alu.sv
// ----------------------------------------------------------------------------
// rrts_alu: shared 32-bit add/subtract unit
// One carry chain serves the compensated sleep request, the sleep countdown
// update with its wake compare, and the saturating time accumulation.
// ----------------------------------------------------------------------------
module rrts_alu (
  input  rrts_pkg::rrts_alu_op_e        op_i,
  input  logic [rrts_pkg::DATA_W-1:0]   a_i,
  input  logic [rrts_pkg::DATA_W-1:0]   b_i,
  output logic [rrts_pkg::DATA_W-1:0]   res_o,
  output logic                          gt_o
);

  localparam int unsigned W = rrts_pkg::DATA_W;

  logic         is_sub;
  logic [W-1:0] b_eff;
  logic [W:0]   sum;

  assign is_sub = (op_i == rrts_pkg::ALU_SUB);
  assign b_eff  = is_sub ? ~b_i : b_i;
  assign sum    = {1'b0, a_i} + {1'b0, b_eff} + {{W{1'b0}}, is_sub};

  // carry out on subtract means no borrow
  assign gt_o  = is_sub && sum[W] && (|sum[W-1:0]);
  assign res_o = (!is_sub && sum[W]) ? {W{1'b1}} : sum[W-1:0];

endmodule

FILE: src/rrts_ram.sv
// ----------------------------------------------------------------------------
// rrts_ram: single-port-write, single-port-read memory with registered read
// Holds the sleep countdowns and the run list.
// ----------------------------------------------------------------------------
module rrts_ram #(
  parameter int unsigned DEPTH = rrts_pkg::MAX_SLOTS_DEF,
  parameter int unsigned WIDTH = rrts_pkg::DATA_W
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

FILE: src/rrts_ctrl.sv
// ----------------------------------------------------------------------------
// rrts_ctrl: command sequencer and slot table
// Holds the slot flags, run position and count, and steps through command
// decode, free-slot search, run-list advance and slot-order rebuild.
// ----------------------------------------------------------------------------
module rrts_ctrl #(
  parameter int unsigned MAX_SLOTS = rrts_pkg::MAX_SLOTS_DEF,
  localparam int unsigned SW = $clog2(MAX_SLOTS),
  localparam int unsigned CW = $clog2(MAX_SLOTS + 1)
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start_i,
  input  rrts_pkg::rrts_req_t           req_i,
  input  logic [7:0]                    sleep_comp_i,
  output logic                          ready_o,
  output logic                          res_valid_o,
  input  logic                          res_take_i,
  output rrts_pkg::rrts_rsp_t           rsp_o,
  output rrts_pkg::rrts_alu_op_e        alu_op_o,
  output logic [rrts_pkg::DATA_W-1:0]   alu_a_o,
  output logic [rrts_pkg::DATA_W-1:0]   alu_b_o,
  input  logic [rrts_pkg::DATA_W-1:0]   alu_res_i,
  input  logic                          alu_gt_i,
  output logic                          slp_we_o,
  output logic [SW-1:0]                 slp_waddr_o,
  output logic [rrts_pkg::DATA_W-1:0]   slp_wdata_o,
  output logic [SW-1:0]                 slp_raddr_o,
  input  logic [rrts_pkg::DATA_W-1:0]   slp_rdata_i,
  output logic                          lst_we_o,
  output logic [SW-1:0]                 lst_waddr_o,
  output logic [SW-1:0]                 lst_wdata_o,
  output logic [SW-1:0]                 lst_raddr_o,
  input  logic [SW-1:0]                 lst_rdata_i
);

  rrts_pkg::rrts_state_e  state_q, state_d;
  rrts_pkg::rrts_req_t    req_q;
  rrts_pkg::rrts_status_e status_q, status_d;
  logic [4:0]             new_q, new_d;
  logic [SW-1:0]          cur_q, cur_d;
  logic [SW-1:0]          scan_q, scan_d;
  logic [CW-1:0]          count_q, count_d;
  logic [CW-1:0]          pos_q, pos_d;
  logic [31:0]            tsr_q, tsr_d;

  logic                   valid_q [MAX_SLOTS];
  rrts_pkg::rrts_mode_e   mode_q  [MAX_SLOTS];
  logic                   lock_q  [MAX_SLOTS];

  // one slot-flag write per cycle
  logic                   fw_en;
  logic [SW-1:0]          fw_idx;
  logic                   fw_valid;
  rrts_pkg::rrts_mode_e   fw_mode;
  logic                   fw_lock;

  logic [SW-1:0]          tgt;
  logic                   id_ok;
  logic                   last_slot;

  assign tgt       = SW'(req_q.thread_id);
  assign id_ok     = (32'(req_q.thread_id) < 32'(MAX_SLOTS)) && valid_q[tgt];
  assign last_slot = (scan_q == SW'(MAX_SLOTS - 1));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= rrts_pkg::S_IDLE;
      count_q <= '0;
      pos_q   <= '0;
      tsr_q   <= '0;
      for (int i = 0; i < int'(MAX_SLOTS); i++) begin
        valid_q[i] <= 1'b0;
        mode_q[i]  <= rrts_pkg::MODE_RUNNING;
        lock_q[i]  <= 1'b0;
      end
    end else begin
      state_q <= state_d;
      count_q <= count_d;
      pos_q   <= pos_d;
      tsr_q   <= tsr_d;
      if (fw_en) begin
        valid_q[fw_idx] <= fw_valid;
        mode_q[fw_idx]  <= fw_mode;
        lock_q[fw_idx]  <= fw_lock;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      req_q <= req_i;
    end
    status_q <= status_d;
    new_q    <= new_d;
    cur_q    <= cur_d;
    scan_q   <= scan_d;
  end

  always_comb begin
    state_d     = state_q;
    status_d    = status_q;
    new_d       = new_q;
    cur_d       = cur_q;
    scan_d      = scan_q;
    count_d     = count_q;
    pos_d       = pos_q;
    tsr_d       = tsr_q;
    fw_en       = 1'b0;
    fw_idx      = tgt;
    fw_valid    = 1'b1;
    fw_mode     = rrts_pkg::MODE_RUNNING;
    fw_lock     = 1'b0;
    alu_op_o    = rrts_pkg::ALU_SUB;
    alu_a_o     = req_q.sleep_ms;
    alu_b_o     = 32'(sleep_comp_i);
    slp_we_o    = 1'b0;
    slp_waddr_o = tgt;
    slp_wdata_o = alu_res_i;
    slp_raddr_o = scan_q + SW'(1);
    lst_we_o    = 1'b0;
    lst_waddr_o = SW'(count_q);
    lst_wdata_o = scan_q;
    lst_raddr_o = SW'(pos_q);
    ready_o     = 1'b0;
    res_valid_o = 1'b0;

    case (state_q)
      rrts_pkg::S_IDLE: begin
        ready_o = 1'b1;
        if (start_i) begin
          state_d = rrts_pkg::S_EXEC;
        end
      end

      rrts_pkg::S_EXEC: begin
        status_d = rrts_pkg::ST_DONE;
        new_d    = '0;
        state_d  = rrts_pkg::S_DONE;
        case (req_q.command)
          rrts_pkg::CMD_TICK: begin
            if (count_q == '0) begin
              state_d = rrts_pkg::S_REB_START;
            end else begin
              pos_d   = pos_q + CW'(1);
              state_d = rrts_pkg::S_ADV_RD;
            end
          end
          rrts_pkg::CMD_CREATE: begin
            scan_d  = '0;
            state_d = rrts_pkg::S_CREATE;
          end
          rrts_pkg::CMD_SLEEP: begin
            if (!id_ok || mode_q[tgt] == rrts_pkg::MODE_KILLREQ) begin
              status_d = rrts_pkg::ST_IGNORED;
            end else begin
              // take the compensation off requests longer than it
              slp_we_o    = 1'b1;
              slp_wdata_o = alu_gt_i ? alu_res_i : req_q.sleep_ms;
              fw_en       = 1'b1;
              fw_mode     = rrts_pkg::MODE_SLEEPING;
              fw_lock     = lock_q[tgt];
            end
          end
          rrts_pkg::CMD_KILL: begin
            if (!id_ok || lock_q[tgt] || mode_q[tgt] == rrts_pkg::MODE_KILLREQ) begin
              status_d = rrts_pkg::ST_IGNORED;
            end else begin
              fw_en   = 1'b1;
              fw_mode = rrts_pkg::MODE_KILLREQ;
              fw_lock = 1'b1;
            end
          end
          rrts_pkg::CMD_PAUSE, rrts_pkg::CMD_UNPAUSE: begin
            if (!id_ok || mode_q[tgt] == rrts_pkg::MODE_KILLREQ) begin
              status_d = rrts_pkg::ST_IGNORED;
            end else begin
              fw_en   = 1'b1;
              fw_mode = (req_q.command == rrts_pkg::CMD_PAUSE) ?
                        rrts_pkg::MODE_PAUSED : rrts_pkg::MODE_RUNNING;
              fw_lock = lock_q[tgt];
            end
          end
          default: begin
            status_d = rrts_pkg::ST_IGNORED;
          end
        endcase
      end

      rrts_pkg::S_CREATE: begin
        fw_idx = scan_q;
        if (!valid_q[scan_q]) begin
          fw_en   = 1'b1;
          new_d   = 5'(scan_q);
          state_d = rrts_pkg::S_DONE;
        end else if (last_slot) begin
          status_d = rrts_pkg::ST_FULL;
          state_d  = rrts_pkg::S_DONE;
        end else begin
          scan_d = scan_q + SW'(1);
        end
      end

      rrts_pkg::S_ADV_RD: begin
        if (pos_q >= count_q) begin
          state_d = rrts_pkg::S_REB_START;
        end else begin
          state_d = rrts_pkg::S_ADV_CHK;
        end
      end

      rrts_pkg::S_ADV_CHK: begin
        if (lock_q[lst_rdata_i]) begin
          pos_d   = pos_q + CW'(1);
          state_d = rrts_pkg::S_ADV_RD;
        end else begin
          cur_d   = lst_rdata_i;
          state_d = rrts_pkg::S_TIME;
        end
      end

      rrts_pkg::S_REB_START: begin
        slp_raddr_o = '0;
        scan_d      = '0;
        count_d     = '0;
        state_d     = rrts_pkg::S_REB;
      end

      rrts_pkg::S_REB: begin
        fw_idx      = scan_q;
        alu_a_o     = slp_rdata_i;
        alu_b_o     = tsr_q;
        slp_waddr_o = scan_q;
        if (valid_q[scan_q]) begin
          case (mode_q[scan_q])
            rrts_pkg::MODE_RUNNING: begin
              lst_we_o = 1'b1;
              if (count_q == '0) begin
                cur_d = scan_q;
              end
              count_d = count_q + CW'(1);
            end
            rrts_pkg::MODE_SLEEPING: begin
              if (alu_gt_i) begin
                slp_we_o = 1'b1;
              end else begin
                fw_en   = 1'b1;
                fw_lock = lock_q[scan_q];
              end
            end
            rrts_pkg::MODE_KILLREQ: begin
              fw_en    = 1'b1;
              fw_valid = 1'b0;
            end
            default: begin
            end
          endcase
        end
        if (last_slot) begin
          pos_d   = '0;
          tsr_d   = '0;
          state_d = rrts_pkg::S_TIME;
        end else begin
          scan_d = scan_q + SW'(1);
        end
      end

      rrts_pkg::S_TIME: begin
        alu_op_o = rrts_pkg::ALU_ADD_SAT;
        alu_a_o  = tsr_q;
        alu_b_o  = 32'(req_q.time_passed);
        tsr_d    = alu_res_i;
        state_d  = rrts_pkg::S_DONE;
      end

      rrts_pkg::S_DONE: begin
        res_valid_o = 1'b1;
        if (res_take_i) begin
          state_d = rrts_pkg::S_IDLE;
        end
      end

      default: begin
        state_d = rrts_pkg::S_IDLE;
      end
    endcase
  end

  assign rsp_o.current_thread = (count_q == '0) ? 5'd0 : 5'(cur_q);
  assign rsp_o.idle           = (count_q == '0);
  assign rsp_o.new_thread     = new_q;
  assign rsp_o.status         = status_q;

endmodule

FILE: src/round_robin_thread_scheduler_unit.sv
// ----------------------------------------------------------------------------
// round_robin_thread_scheduler_unit: round-robin thread scheduler
// Slot table with sleep timers and a run list rebuilt in slot order.
// ----------------------------------------------------------------------------
//
//   channel   signals                               direction
//   request   in_valid_i / in_stall_o / in_data_i   in  (command + operands)
//   response  out_valid_o / out_stall_i / out_data_o out (selection + status)
//   config    cfg_we_i / cfg_data_i                 in  (sleep compensation)
//
// Sequencing: one request at a time. Create scans the slots upward for the
// lowest free one; a tick probes the run list and skips locked entries. A
// tick that starts from idle or passes the end of the list rebuilds: the
// rebuild walks every slot once, one slot a cycle, through the shared adder
// and the countdown memory port. The next request is taken in the cycle
// after the response moves to the output register.
// Reset: asynchronous, active low; no clearing pass, all slots start free
// and the idle thread selected. A stalled response holds in the output
// register while the next request is already taken in.
//
module round_robin_thread_scheduler_unit #(
  parameter int unsigned MAX_SLOTS = rrts_pkg::MAX_SLOTS_DEF
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_stall_o,
  input  rrts_pkg::rrts_req_t  in_data_i,
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  output rrts_pkg::rrts_rsp_t  out_data_o,
  input  logic                 cfg_we_i,
  input  logic [7:0]           cfg_data_i
);

  localparam int unsigned SW = $clog2(MAX_SLOTS);

  logic                         ready;
  logic                         start;
  logic                         res_valid;
  logic                         res_take;
  rrts_pkg::rrts_rsp_t          rsp;
  logic [7:0]                   sleep_comp_q;

  rrts_pkg::rrts_alu_op_e       alu_op;
  logic [rrts_pkg::DATA_W-1:0]  alu_a;
  logic [rrts_pkg::DATA_W-1:0]  alu_b;
  logic [rrts_pkg::DATA_W-1:0]  alu_res;
  logic                         alu_gt;

  logic                         slp_we;
  logic [SW-1:0]                slp_waddr;
  logic [rrts_pkg::DATA_W-1:0]  slp_wdata;
  logic [SW-1:0]                slp_raddr;
  logic [rrts_pkg::DATA_W-1:0]  slp_rdata;

  logic                         lst_we;
  logic [SW-1:0]                lst_waddr;
  logic [SW-1:0]                lst_wdata;
  logic [SW-1:0]                lst_raddr;
  logic [SW-1:0]                lst_rdata;

  logic                         out_valid_q;
  rrts_pkg::rrts_rsp_t          out_data_q;

  // Hold off requests while the sequencer works on one.
  assign in_stall_o = !ready;
  assign start      = in_valid_i && ready;

  // Load the output register when it is empty or being drained this cycle.
  assign res_take = res_valid && (!out_valid_q || !out_stall_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sleep_comp_q <= rrts_pkg::SLEEP_COMP_RST;
      out_valid_q  <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        sleep_comp_q <= cfg_data_i;
      end
      if (res_take) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_take) begin
      out_data_q <= rsp;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

  rrts_ctrl #(
    .MAX_SLOTS (MAX_SLOTS)
  ) u_ctrl (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .start_i      (start),
    .req_i        (in_data_i),
    .sleep_comp_i (sleep_comp_q),
    .ready_o      (ready),
    .res_valid_o  (res_valid),
    .res_take_i   (res_take),
    .rsp_o        (rsp),
    .alu_op_o     (alu_op),
    .alu_a_o      (alu_a),
    .alu_b_o      (alu_b),
    .alu_res_i    (alu_res),
    .alu_gt_i     (alu_gt),
    .slp_we_o     (slp_we),
    .slp_waddr_o  (slp_waddr),
    .slp_wdata_o  (slp_wdata),
    .slp_raddr_o  (slp_raddr),
    .slp_rdata_i  (slp_rdata),
    .lst_we_o     (lst_we),
    .lst_waddr_o  (lst_waddr),
    .lst_wdata_o  (lst_wdata),
    .lst_raddr_o  (lst_raddr),
    .lst_rdata_i  (lst_rdata)
  );

  // Shared adder: compensation, countdown update and time accumulation.
  rrts_alu u_alu (
    .op_i  (alu_op),
    .a_i   (alu_a),
    .b_i   (alu_b),
    .res_o (alu_res),
    .gt_o  (alu_gt)
  );

  // Sleep countdown per slot; written by sleep and by the rebuild walk.
  rrts_ram #(
    .DEPTH (MAX_SLOTS),
    .WIDTH (rrts_pkg::DATA_W)
  ) u_sleep_ram (
    .clk_i   (clk_i),
    .we_i    (slp_we),
    .waddr_i (slp_waddr),
    .wdata_i (slp_wdata),
    .raddr_i (slp_raddr),
    .rdata_o (slp_rdata)
  );

  // Run list in slot order; valid below the run count only.
  rrts_ram #(
    .DEPTH (MAX_SLOTS),
    .WIDTH (SW)
  ) u_list_ram (
    .clk_i   (clk_i),
    .we_i    (lst_we),
    .waddr_i (lst_waddr),
    .wdata_i (lst_wdata),
    .raddr_i (lst_raddr),
    .rdata_o (lst_rdata)
  );

endmodule

FILE: tb/sv/rrts_sched_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rrts_sched_checker: scoreboard for the round-robin thread scheduler
// Watches the request, response and config ports, keeps its own copy of the
// slot table and run list, predicts one response per accepted request and
// compares it field by field with what the scheduler returns.
// ----------------------------------------------------------------------------
module rrts_sched_checker
  import rrts_pkg::*;
#(
  parameter int unsigned NSLOTS = MAX_SLOTS_DEF
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  input  logic       in_stall_i,
  input  rrts_req_t  in_data_i,
  input  logic       out_valid_i,
  input  logic       out_stall_i,
  input  rrts_rsp_t  out_data_i,
  input  logic       cfg_we_i,
  input  logic [7:0] cfg_data_i,
  output int         err_cnt_o,
  output int         pending_o,
  output int         n_req_o,
  output int         n_applied_o,
  output int         n_rebuild_o,
  output int         n_wake_o,
  output int         n_freed_o,
  output int         n_full_o,
  output int         n_ignored_o
);

  // mirrored scheduler state
  logic        slot_used [NSLOTS];
  rrts_mode_e  slot_mode_q [NSLOTS];
  logic        slot_lock [NSLOTS];
  logic [31:0] nap_left [NSLOTS];
  logic [4:0]  rota [NSLOTS];
  int unsigned rota_len;
  int unsigned rota_pos;
  logic [31:0] time_acc;
  logic        idle_sel;
  logic [7:0]  comp;

  rrts_rsp_t   pending_rsp_q [$];
  int          errs, reqs, applied, rebuilds, wakes, freed, fulls, ignored;

  // Walk the slots in order: list runners, age or wake sleepers, free kills.
  task automatic rebuild_rota();
    logic [31:0] span;
    span     = time_acc;
    rota_len = 0;
    for (int i = 0; i < NSLOTS; i++) begin
      if (!slot_used[i]) continue;
      case (slot_mode_q[i])
        MODE_RUNNING: begin
          rota[rota_len] = 5'(i);
          rota_len++;
        end
        MODE_SLEEPING: begin
          if (nap_left[i] <= span) begin
            slot_mode_q[i] = MODE_RUNNING;
            wakes++;
          end else begin
            nap_left[i] -= span;
          end
        end
        MODE_KILLREQ: begin
          slot_used[i]   = 1'b0;
          slot_mode_q[i] = MODE_RUNNING;
          slot_lock[i]   = 1'b0;
          freed++;
        end
        default: ;
      endcase
    end
    idle_sel = (rota_len == 0);
    rota_pos = 0;
    time_acc = '0;
    rebuilds++;
  endtask

  // Advance past locked entries, rebuild when idle or past the end, then bank the time.
  task automatic advance_tick(input logic [15:0] passed);
    if (idle_sel || rota_len == 0) begin
      rebuild_rota();
    end else begin
      rota_pos++;
      while (rota_pos < rota_len && slot_lock[rota[rota_pos]]) rota_pos++;
      if (rota_pos >= rota_len) rebuild_rota();
    end
    if (time_acc > 32'hFFFF_FFFF - {16'h0, passed}) time_acc = 32'hFFFF_FFFF;
    else time_acc += {16'h0, passed};
  endtask

  task automatic predict_request(input rrts_req_t rq, output rrts_rsp_t rsp);
    rrts_status_e st;
    logic [4:0]   made;
    logic [4:0]   s;
    logic         ok;
    logic [31:0]  ms;
    st   = ST_DONE;
    made = '0;
    s    = rq.thread_id;
    ok   = (s < NSLOTS) && slot_used[s];
    case (rq.command)
      CMD_TICK: advance_tick(rq.time_passed);
      CMD_CREATE: begin
        st = ST_FULL;
        for (int i = 0; i < NSLOTS; i++) begin
          if (!slot_used[i]) begin
            slot_used[i]   = 1'b1;
            slot_mode_q[i] = MODE_RUNNING;
            slot_lock[i]   = 1'b0;
            nap_left[i]    = '0;
            made           = 5'(i);
            st             = ST_DONE;
            break;
          end
        end
      end
      CMD_SLEEP: begin
        if (!ok || slot_mode_q[s] == MODE_KILLREQ) begin
          st = ST_IGNORED;
        end else begin
          ms = rq.sleep_ms;
          if (ms > {24'h0, comp}) ms -= {24'h0, comp};
          nap_left[s]    = ms;
          slot_mode_q[s] = MODE_SLEEPING;
        end
      end
      CMD_KILL: begin
        if (!ok || slot_lock[s] || slot_mode_q[s] == MODE_KILLREQ) begin
          st = ST_IGNORED;
        end else begin
          slot_mode_q[s] = MODE_KILLREQ;
          slot_lock[s]   = 1'b1;
        end
      end
      CMD_PAUSE, CMD_UNPAUSE: begin
        if (!ok || slot_mode_q[s] == MODE_KILLREQ) st = ST_IGNORED;
        else slot_mode_q[s] = (rq.command == CMD_PAUSE) ? MODE_PAUSED : MODE_RUNNING;
      end
      default: st = ST_IGNORED;
    endcase
    rsp.current_thread = (!idle_sel && rota_pos < rota_len) ? rota[rota_pos] : '0;
    rsp.idle           = idle_sel;
    rsp.new_thread     = made;
    rsp.status         = st;
    if (st == ST_FULL) fulls++;
    if (st == ST_IGNORED) ignored++;
    else applied++;
  endtask

  task automatic compare_field(input string name, input logic [7:0] want,
                               input logic [7:0] got);
    if (got !== want) begin
      $error("%s: expected %0d, actual %0d", name, want, got);
      errs++;
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin : watch
    rrts_rsp_t want_rsp;
    if (!rst_ni) begin
      for (int i = 0; i < NSLOTS; i++) begin
        slot_used[i]   = 1'b0;
        slot_mode_q[i] = MODE_RUNNING;
        slot_lock[i]   = 1'b0;
      end
      rota_len = 0;
      rota_pos = 0;
      time_acc = '0;
      idle_sel = 1'b1;
      comp     = SLEEP_COMP_RST;
      pending_rsp_q.delete();
    end else begin
      if (cfg_we_i) comp = cfg_data_i;
      if (in_valid_i && !in_stall_i) begin
        predict_request(in_data_i, want_rsp);
        pending_rsp_q.push_back(want_rsp);
        reqs++;
      end
      if (out_valid_i && !out_stall_i) begin
        if (pending_rsp_q.size() == 0) begin
          $error("response with no request outstanding: %p", out_data_i);
          errs++;
        end else begin
          want_rsp = pending_rsp_q.pop_front();
          compare_field("current_thread", 8'(want_rsp.current_thread),
                        8'(out_data_i.current_thread));
          compare_field("idle", 8'(want_rsp.idle), 8'(out_data_i.idle));
          compare_field("new_thread", 8'(want_rsp.new_thread),
                        8'(out_data_i.new_thread));
          compare_field("status", 8'(want_rsp.status), 8'(out_data_i.status));
        end
      end
    end
    err_cnt_o   <= errs;
    pending_o   <= pending_rsp_q.size();
    n_req_o     <= reqs;
    n_applied_o <= applied;
    n_rebuild_o <= rebuilds;
    n_wake_o    <= wakes;
    n_freed_o   <= freed;
    n_full_o    <= fulls;
    n_ignored_o <= ignored;
  end

endmodule

FILE: tb/sv/tb_round_robin_thread_scheduler_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_round_robin_thread_scheduler_unit: testbench of the thread scheduler
// Drives a directed opening and three random phases of scheduler requests
// under changing sleep compensation and idling; a checker beside the block
// predicts and compares every response, this module gives the verdict.
// ----------------------------------------------------------------------------
module tb_round_robin_thread_scheduler_unit;
  import rrts_pkg::*;

  // Codes the block has no name for; both must come back ignored.
  localparam logic [2:0] CMD_UNUSED_6 = 3'd6;
  localparam logic [2:0] CMD_UNUSED_7 = 3'd7;

  logic       clk_i;
  logic       rst_n     = 1'b0;
  logic       in_valid  = 1'b0;
  logic       in_stall;
  rrts_req_t  in_data   = '0;
  logic       out_valid;
  logic       out_stall = 1'b0;
  rrts_rsp_t  out_data;
  logic       cfg_we    = 1'b0;
  logic [7:0] cfg_data  = '0;

  int err_cnt, pending, n_req, n_applied, n_rebuild, n_wake, n_freed;
  int n_full, n_ignored;

  // idling knobs, percent of cycles; hold_left counts a forced receiver stall
  int         in_idle_pct  = 0;
  int         out_idle_pct = 0;
  int         hold_left    = 0;
  logic [7:0] cur_comp     = SLEEP_COMP_RST;

  round_robin_thread_scheduler_unit u_top (
    .clk_i       (clk_i),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_stall_o  (in_stall),
    .in_data_i   (in_data),
    .out_valid_o (out_valid),
    .out_stall_i (out_stall),
    .out_data_o  (out_data),
    .cfg_we_i    (cfg_we),
    .cfg_data_i  (cfg_data)
  );

  rrts_sched_checker u_check (
    .clk_i       (clk_i),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_stall_i  (in_stall),
    .in_data_i   (in_data),
    .out_valid_i (out_valid),
    .out_stall_i (out_stall),
    .out_data_i  (out_data),
    .cfg_we_i    (cfg_we),
    .cfg_data_i  (cfg_data),
    .err_cnt_o   (err_cnt),
    .pending_o   (pending),
    .n_req_o     (n_req),
    .n_applied_o (n_applied),
    .n_rebuild_o (n_rebuild),
    .n_wake_o    (n_wake),
    .n_freed_o   (n_freed),
    .n_full_o    (n_full),
    .n_ignored_o (n_ignored)
  );

  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  // Hard stop: far beyond the slowest legal run (about 1.5k requests plus
  // random idling on both sides).
  initial begin
    #2_000_000;
    $display("FAIL");
    $finish;
  end

  // Receiver: stall at random, or hold for a counted stretch when asked.
  // Drive on the falling edge so the block samples a settled stall.
  initial begin
    forever begin
      @(negedge clk_i);
      if (hold_left > 0) begin
        out_stall <= 1'b1;
        hold_left--;
      end else begin
        out_stall <= ($urandom_range(0, 99) < out_idle_pct);
      end
    end
  end

  // Offer one request; insert random idle cycles first, then hold the
  // payload until the rising edge at which the block takes it.
  task automatic push_request(input rrts_req_t rq);
    while ($urandom_range(0, 99) < in_idle_pct) begin
      @(negedge clk_i);
      in_valid <= 1'b0;
    end
    @(negedge clk_i);
    in_valid <= 1'b1;
    in_data  <= rq;
    @(posedge clk_i);
    while (in_stall) @(posedge clk_i);
  endtask

  task automatic issue(input logic [2:0] cmd, input logic [4:0] id,
                       input logic [31:0] ms = '0, input logic [15:0] tp = '0);
    rrts_req_t rq;
    rq.command     = cmd;
    rq.thread_id   = id;
    rq.sleep_ms    = ms;
    rq.time_passed = tp;
    push_request(rq);
  endtask

  // Drop valid and wait until every outstanding response has come back.
  task automatic wait_drained();
    @(negedge clk_i);
    in_valid <= 1'b0;
    while (pending != 0) @(negedge clk_i);
  endtask

  // Write sleep compensation only with the block empty.
  task automatic set_compensation(input logic [7:0] val);
    wait_drained();
    repeat (4) @(negedge clk_i);
    cfg_we   <= 1'b1;
    cfg_data <= val;
    @(negedge clk_i);
    cfg_we   <= 1'b0;
    cur_comp = val;
  endtask

  // Bias targets toward the low slots, which are most often occupied.
  function automatic logic [4:0] pick_slot();
    return ($urandom_range(0, 9) < 7) ? 5'($urandom_range(0, 11)) : 5'($urandom);
  endfunction

  // Sleep lengths: mostly short enough to wake, some around the
  // compensation value, some anywhere in 32 bits.
  function automatic logic [31:0] pick_nap();
    case ($urandom_range(0, 9))
      0, 1, 2, 3: return $urandom_range(0, 400);
      4:          return {24'h0, cur_comp} + $urandom_range(0, 2) - 1;
      5:          return {24'h0, cur_comp};
      6, 7:       return $urandom_range(0, 20000);
      default:    return $urandom;
    endcase
  endfunction

  function automatic logic [15:0] pick_time();
    case ($urandom_range(0, 19))
      0, 1, 2:          return 16'($urandom);
      3, 4, 5, 6, 7:    return 16'($urandom_range(0, 2000));
      default:          return 16'($urandom_range(0, 60));
    endcase
  endfunction

  task automatic tick_burst(input int n);
    repeat (n) issue(CMD_TICK, 5'($urandom), $urandom, pick_time());
  endtask

  // One random phase: fill the table to overflow, then well-formed command
  // sequences with random content and some noise, until enough requests
  // have acted on the table. With pressure set, hold the receiver for a
  // long stretch mid-phase and later pause the sender until drained.
  task automatic run_phase(input int in_pct, input int out_pct, input int quota,
                           input bit pressure);
    int         goal;
    bit         held;
    bit         paused;
    logic [4:0] id;
    rrts_req_t  rq;
    in_idle_pct  = in_pct;
    out_idle_pct = out_pct;
    goal         = n_applied + quota;
    held         = !pressure;
    paused       = !pressure;
    repeat (34) issue(CMD_CREATE, 5'($urandom), $urandom, 16'($urandom));
    while (n_applied < goal) begin
      if (!held && n_applied > goal - quota / 2) begin
        hold_left = 400;
        held      = 1'b1;
      end
      if (!paused && n_applied > goal - quota / 4) begin
        wait_drained();
        paused = 1'b1;
      end
      id = pick_slot();
      case ($urandom_range(0, 9))
        0, 1, 2: tick_burst($urandom_range(1, 40));
        3: repeat ($urandom_range(1, 6)) issue(CMD_CREATE, 5'($urandom));
        4: begin
          issue(CMD_KILL, id);
          tick_burst($urandom_range(0, 8));
        end
        5: begin
          issue(CMD_SLEEP, id, pick_nap());
          tick_burst($urandom_range(0, 12));
        end
        6: begin
          issue(CMD_PAUSE, id);
          tick_burst($urandom_range(0, 5));
          issue(CMD_UNPAUSE, id);
        end
        default: begin
          // noise: any code, any target, any operands
          rq.command     = 3'($urandom_range(0, 7));
          rq.thread_id   = 5'($urandom);
          rq.sleep_ms    = $urandom;
          rq.time_passed = 16'($urandom);
          push_request(rq);
        end
      endcase
    end
  endtask

  initial begin
    // Hold reset low, then release it away from the rising edge.
    repeat (8) @(posedge clk_i);
    @(negedge clk_i);
    rst_n <= 1'b1;
    repeat (2) @(negedge clk_i);

    // Directed opening at the reset compensation of 10.
    in_idle_pct  = 29;
    out_idle_pct = 88;
    issue(CMD_TICK, 5'd0, '0, 16'hFFFF);           // tick on an empty table
    issue(CMD_SLEEP, 5'd31, 32'hFFFF_FFFF);        // target slot not in use
    issue(CMD_UNUSED_6, 5'd31, 32'hFFFF_FFFF, 16'hFFFF);
    issue(CMD_UNUSED_7, 5'd0);
    repeat (3) issue(CMD_CREATE, 5'd0);            // take slots 0..2
    issue(CMD_TICK, 5'd0);                         // idle, so rebuild at once
    issue(CMD_SLEEP, 5'd1, 32'd10);                // equal to comp: kept as is
    issue(CMD_SLEEP, 5'd2, 32'd11);                // one above comp: cut to 1
    issue(CMD_PAUSE, 5'd0);                        // listed slot stays selected
    issue(CMD_TICK, 5'd0, '0, 16'd5);              // sleeper still selected
    issue(CMD_KILL, 5'd1);
    issue(CMD_KILL, 5'd1);                         // kill already pending
    issue(CMD_SLEEP, 5'd1, '0);                    // commands on a pending kill
    issue(CMD_PAUSE, 5'd1);
    issue(CMD_UNPAUSE, 5'd1);
    issue(CMD_TICK, 5'd0);
    issue(CMD_TICK, 5'd0);                         // rebuild: free, wake, go idle
    issue(CMD_UNPAUSE, 5'd0);
    issue(CMD_CREATE, 5'd0);                       // reuse the freed slot
    issue(CMD_TICK, 5'd0);
    issue(CMD_KILL, 5'd1);
    issue(CMD_TICK, 5'd0);                         // skip the locked entry
    issue(CMD_SLEEP, 5'd0, 32'hFFFF_FFFF);
    issue(CMD_TICK, 5'd0);
    issue(CMD_SLEEP, 5'd0, '0);
    issue(CMD_TICK, 5'd0);

    // Random phases across the compensation range, idling swapped, then none.
    set_compensation(8'd255);
    run_phase(29, 88, 425, 1'b1);
    set_compensation(8'd0);
    run_phase(88, 29, 425, 1'b1);
    set_compensation(8'($urandom_range(1, 254)));
    run_phase(0, 0, 425, 1'b0);

    // Drain, then give the block its worst-case latency to show anything extra.
    wait_drained();
    repeat (150) @(posedge clk_i);

    $display("Covered %0d requests (%0d acted on, %0d ignored), %0d creates on a full table,",
             n_req, n_applied, n_ignored, n_full);
    $display("%0d run-list rebuilds, %0d sleepers woken, %0d slots freed, compensation 10/255/0/%0d.",
             n_rebuild, n_wake, n_freed, cur_comp);
    if (err_cnt == 0 && pending == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
